// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL in this folder.
// Each one expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk. The check is off while reset is held.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition on one edge leads to a consequence on the next edge.
`define ASSERT_NEXT(name, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ===== sv/lrr_pkg.sv =====
// Package for the Legendre row reduction block: datapath widths, types and sizes.
// It also holds the command codes and the Q.16 recurrence ratio tables. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

  localparam int VAL_W   = 42;  // recurrence values, signed Q.16
  localparam int SUM_W   = 48;
  localparam int COEF_W  = 32;
  localparam int IDX_W   = 8;
  localparam int DEG_W   = 4;
  localparam int POS_W   = 16;
  localparam int RATIO_W = 17;
  localparam int MA_W    = 25;  // multiplier operand a: one 24-bit chunk plus sign
  localparam int MB_W    = 18;  // multiplier operand b
  localparam int MP_W    = MA_W + MB_W;
  localparam int SPLIT   = 24;

  // Built sizes; the field widths above and the ratio tables below are fixed to these.
  localparam int MAX_DEGREE  = 15;
  localparam int STORE_DEPTH = 136;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [MP_W-1:0]  prod_t;

  localparam logic signed [63:0] Y_HI = (64'sd1 <<< 40) - 64'sd1;
  localparam logic signed [63:0] Y_LO = -(64'sd1 <<< 40);
  localparam logic signed [63:0] S_HI = 64'sd2147483647;
  localparam logic signed [63:0] S_LO = -64'sd2147483648;

  // (2k+1)/(k+1) in Q.16, rounded to nearest.
  function automatic logic [RATIO_W-1:0] ratio_a(input logic [DEG_W-1:0] k);
    logic [RATIO_W-1:0] r;
    unique case (k)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd98304;
      4'd2:  r = 17'd109227;
      4'd3:  r = 17'd114688;
      4'd4:  r = 17'd117965;
      4'd5:  r = 17'd120149;
      4'd6:  r = 17'd121710;
      4'd7:  r = 17'd122880;
      4'd8:  r = 17'd123790;
      4'd9:  r = 17'd124518;
      4'd10: r = 17'd125114;
      4'd11: r = 17'd125611;
      4'd12: r = 17'd126031;
      4'd13: r = 17'd126391;
      4'd14: r = 17'd126703;
      4'd15: r = 17'd126976;
    endcase
    return r;
  endfunction

  // (k+1)/(k+2) in Q.16, rounded to nearest.
  function automatic logic [RATIO_W-1:0] ratio_b(input logic [DEG_W-1:0] k);
    logic [RATIO_W-1:0] r;
    unique case (k)
      4'd0:  r = 17'd32768;
      4'd1:  r = 17'd43691;
      4'd2:  r = 17'd49152;
      4'd3:  r = 17'd52429;
      4'd4:  r = 17'd54613;
      4'd5:  r = 17'd56174;
      4'd6:  r = 17'd57344;
      4'd7:  r = 17'd58254;
      4'd8:  r = 17'd58982;
      4'd9:  r = 17'd59578;
      4'd10: r = 17'd60075;
      4'd11: r = 17'd60495;
      4'd12: r = 17'd60855;
      4'd13: r = 17'd61167;
      4'd14: r = 17'd61440;
      4'd15: r = 17'd61681;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/legendre_row_reduction_top.sv =====
// Legendre row reduction: coefficient store, sequencer and one shared multiplier.
// Depends on lrr_pkg and on assert_macros.svh.
//
// Usage: the input channel (in_valid/in_ready) carries an item that is either a
// coefficient write (in_command = 0) or an evaluation at in_position (in_command = 1).
// A write produces no result. An evaluation produces one result per row, for rows
// 0 to D (D = degree, limited to MAX_DEGREE), on the out_valid/out_ready channel,
// with out_last set on row D.
// Each row is computed with the single 25x18 multiplier, which each recurrence
// step uses six times, with the wide operands split at bit 24 into a low and a
// high chunk. After an evaluation is accepted, in_ready stays low until the last
// row has been passed to the output register.
// The degree register is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, as the block does not enforce this. Reset sets the degree
// to 2 and empties the output register. The coefficient store is not cleared, so
// every entry must be written before an evaluation reads it. If the receiver stalls,
// a row waits in the output register and the sequencer waits with the next row.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module legendre_row_reduction_top import lrr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [IDX_W-1:0]         in_coef_index,
  input  logic signed [COEF_W-1:0] in_coef_value,
  input  logic signed [POS_W-1:0]  in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DEG_W-1:0]         out_row_index,
  output logic signed [COEF_W-1:0] out_row_sum,
  output logic                     out_last,
  output logic                     out_saturated,
  input  logic                     cfg_we,
  input  logic [DEG_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_LOAD2 = 4'd2;
  localparam logic [3:0] S_M0    = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_M4    = 4'd7;
  localparam logic [3:0] S_M5    = 4'd8;
  localparam logic [3:0] S_M6    = 4'd9;
  localparam logic [3:0] S_M7    = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0]              state_r, state_nxt;
  logic [DEG_W-1:0]        degree_r;
  logic                    out_valid_r;
  logic [DEG_W-1:0]        out_row_index_r;
  logic signed [COEF_W-1:0] out_row_sum_r;
  logic                    out_last_r, out_saturated_r;

  logic signed [POS_W-1:0] x_r;
  logic [DEG_W-1:0]        d_r, lx_r, n_r, k_r;
  logic [IDX_W-1:0]        base_r;
  val_t                    y1_r, y2_r, t_r;
  logic signed [SUM_W-1:0] sum_r;
  prod_t                   acc_r, prod_r;
  logic                    flag_r;
  logic signed [COEF_W-1:0] res_sum_r;
  logic                    res_sat_r;

  logic [COEF_W-1:0]       mem [STORE_DEPTH];
  logic signed [COEF_W-1:0] rdata_r;
  logic                    rd_oor_r;

  logic                    in_fire, wr_en, rd_en, emit_go, eval_start;
  logic [IDX_W-1:0]        rd_idx;
  logic [31:0]             rd_ext, wr_ext;
  logic [DEG_W-1:0]        d_eff;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  prod_t                   mul_p;
  logic signed [63:0]      comb_full, coef64, y_full, s_full;

  assign in_ready      = (state_r == S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign wr_en         = in_fire && (in_command == CMD_WRITE) &&
                         (32'(in_coef_index) < 32'(STORE_DEPTH));
  assign eval_start    = in_fire && (in_command == CMD_EVAL);
  assign emit_go       = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign d_eff         = (32'(degree_r) > 32'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_r;

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_sum   = out_row_sum_r;
  assign out_last      = out_last_r;
  assign out_saturated = out_saturated_r;

  // The store is read at the top coefficient of a row, then once per step.
  assign rd_en  = (state_r == S_LOAD) || (state_r == S_M0);
  assign rd_idx = (state_r == S_LOAD) ? IDX_W'(base_r + IDX_W'(n_r))
                                      : IDX_W'(base_r + IDX_W'(k_r));
  assign rd_ext = 32'(rd_idx);
  assign wr_ext = 32'(in_coef_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ext[AW-1:0]] <= in_coef_value;
    end
    if (rd_en) begin
      rdata_r  <= mem[rd_ext[AW-1:0]];
      rd_oor_r <= (rd_ext >= 32'(STORE_DEPTH));
    end
  end

  assign coef64 = rd_oor_r ? 64'sd0 : 64'(rdata_r);

  // Shared multiplier: the low 24-bit chunk or the high chunk of a wide value times x or a ratio.
  always_comb begin
    mul_a = $signed({1'b0, y1_r[SPLIT-1:0]});
    mul_b = MB_W'(x_r);
    unique case (state_r)
      S_M1: mul_a = MA_W'($signed(y1_r[VAL_W-1:SPLIT]));
      S_M3: begin
        mul_a = $signed({1'b0, t_r[SPLIT-1:0]});
        mul_b = $signed({1'b0, ratio_a(k_r)});
      end
      S_M4: begin
        mul_a = MA_W'($signed(t_r[VAL_W-1:SPLIT]));
        mul_b = $signed({1'b0, ratio_a(k_r)});
      end
      S_M5: begin
        mul_a = $signed({1'b0, y2_r[SPLIT-1:0]});
        mul_b = $signed({1'b0, ratio_b(k_r)});
      end
      S_M6: begin
        mul_a = MA_W'($signed(y2_r[VAL_W-1:SPLIT]));
        mul_b = $signed({1'b0, ratio_b(k_r)});
      end
      default: ;
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  // Low partial product in acc_r, high partial product in prod_r.
  assign comb_full = 64'(acc_r) + (64'(prod_r) <<< SPLIT);
  assign y_full    = 64'(sum_r) - (comb_full >>> 16);
  assign s_full    = (comb_full >>> 15) - (64'(y2_r) >>> 1) + coef64;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (eval_start) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_LOAD2;
      S_LOAD2: state_nxt = (n_r == '0) ? S_EMIT : S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = (k_r == '0) ? S_EMIT : S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_M6;
      S_M6:    state_nxt = S_M7;
      S_M7:    state_nxt = S_M0;
      S_EMIT:  if (emit_go) state_nxt = (lx_r == d_r) ? S_IDLE : S_LOAD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      degree_r    <= 4'd2;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        degree_r <= cfg_wdata;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    unique case (state_r)
      S_IDLE: begin
        if (eval_start) begin
          x_r    <= in_position;
          d_r    <= d_eff;
          n_r    <= d_eff;
          lx_r   <= '0;
          base_r <= '0;
        end
      end
      S_LOAD: flag_r <= 1'b0;
      S_LOAD2: begin
        y1_r      <= VAL_W'(coef64);
        y2_r      <= '0;
        res_sum_r <= COEF_W'(coef64);
        res_sat_r <= 1'b0;
        k_r       <= DEG_W'(n_r - 1'b1);
      end
      S_M1: acc_r <= prod_r;
      S_M2: begin
        t_r <= VAL_W'(comb_full >>> 15);
        if (s_full > S_HI) begin
          res_sum_r <= COEF_W'(S_HI);
          res_sat_r <= 1'b1;
        end else if (s_full < S_LO) begin
          res_sum_r <= COEF_W'(S_LO);
          res_sat_r <= 1'b1;
        end else begin
          res_sum_r <= COEF_W'(s_full);
          res_sat_r <= flag_r;
        end
      end
      S_M4: acc_r <= prod_r;
      S_M5: sum_r <= SUM_W'((comb_full >>> 16) + coef64);
      S_M6: acc_r <= prod_r;
      S_M7: begin
        y2_r <= y1_r;
        k_r  <= DEG_W'(k_r - 1'b1);
        if (y_full > Y_HI) begin
          y1_r   <= VAL_W'(Y_HI);
          flag_r <= 1'b1;
        end else if (y_full < Y_LO) begin
          y1_r   <= VAL_W'(Y_LO);
          flag_r <= 1'b1;
        end else begin
          y1_r <= VAL_W'(y_full);
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_row_index_r <= lx_r;
          out_row_sum_r   <= res_sum_r;
          out_last_r      <= (lx_r == d_r);
          out_saturated_r <= res_sat_r;
          lx_r            <= DEG_W'(lx_r + 1'b1);
          base_r          <= IDX_W'(base_r + IDX_W'(n_r) + 1'b1);
          n_r             <= DEG_W'(n_r - 1'b1);
        end
      end
      default: ;
    endcase
  end

  `ASSERT_CLK(a_last_row, (out_valid_r && out_last_r) |-> (out_row_index_r == d_r), "last item is not the final row")
  `ASSERT_CLK(a_step_order, (state_r == S_M0) |-> (k_r < n_r), "step index not below row order")
  `ASSERT_CLK(a_y1_range, (state_r == S_M0) |-> ((64'(y1_r) <= Y_HI) && (64'(y1_r) >= Y_LO)), "recurrence value out of range")
  `ASSERT_NEXT(a_done_idle, emit_go && (lx_r == d_r), state_r == S_IDLE, "sequencer did not return to idle")

endmodule

`default_nettype wire
